// ===== rtl/tcapq_pkg.sv =====
package tcapq_pkg;

  localparam int ACTION_W    = 2;
  localparam int CLIENT_ID_W = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;
  localparam int CAP_W       = 5;
  localparam int MAX_WAIT_W  = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_SEL_BIT = 2;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 16;
  localparam int DEF_AGE_BITS    = 16;

  localparam logic [CAP_W-1:0]      CAP_RESET      = 5'd16;
  localparam logic [MAX_WAIT_W-1:0] MAX_WAIT_RESET = 16'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRIO_ENQ = 2'd0,
    ACT_FIFO_ENQ = 2'd1,
    ACT_DEQ      = 2'd2,
    ACT_PROMOTE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_MAX_WAIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic sweep;
    logic restart;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic sweep_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/tcapq_if.sv =====
interface tcapq_req_if;
  import tcapq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [CLIENT_ID_W-1:0] client_id;
  logic                   premium;

  modport source (output valid, action, client_id, premium, input ready);
  modport sink (input valid, action, client_id, premium, output ready);
endinterface

interface tcapq_rsp_if;
  import tcapq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [CLIENT_ID_W-1:0] out_client_id;
  logic [OCC_W-1:0]       occupancy;

  modport source (output valid, status, out_client_id, occupancy, input ready);
  modport sink (input valid, status, out_client_id, occupancy, output ready);
endinterface

// ===== rtl/tcapq_ctrl.sv =====
module tcapq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  tcapq_pkg::action_t action,
  input  tcapq_pkg::dp_sts_t sts,
  output tcapq_pkg::dp_cmd_t cmd
);
  import tcapq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (action)
            ACT_PRIO_ENQ: state_next = sts.full ? S_COMMIT : S_SWEEP;
            ACT_FIFO_ENQ: state_next = S_COMMIT;
            ACT_DEQ:      state_next = sts.empty ? S_COMMIT : S_SWEEP;
            ACT_PROMOTE:  state_next = sts.empty ? S_COMMIT : S_SCAN;
            default:      state_next = S_COMMIT;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.sweep_done) begin
          cmd.restart = 1'b1;
          state_next  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tcapq_dp.sv =====
module tcapq_dp #(
  parameter int QUEUE_DEPTH = tcapq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = tcapq_pkg::DEF_ID_BITS,
  parameter int AGE_BITS    = tcapq_pkg::DEF_AGE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcapq_pkg::dp_cmd_t                 cmd,
  output tcapq_pkg::dp_sts_t                 sts,
  input  tcapq_pkg::action_t                 action,
  input  logic [tcapq_pkg::CLIENT_ID_W-1:0]  client_id,
  input  logic                               premium,
  input  logic [tcapq_pkg::CAP_W-1:0]        capacity,
  input  logic [tcapq_pkg::MAX_WAIT_W-1:0]   max_wait,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tcapq_pkg::STATUS_W-1:0]     out_status,
  output logic [tcapq_pkg::CLIENT_ID_W-1:0]  out_client_id,
  output logic [tcapq_pkg::OCC_W-1:0]        out_occupancy
);
  import tcapq_pkg::*;

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W   = ID_BITS + 1 + AGE_BITS;
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam int CAP_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int AGE_CMP_W = (AGE_BITS > MAX_WAIT_W) ? AGE_BITS : MAX_WAIT_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] q;

  logic               bank;
  logic [CNT_W-1:0]   count;
  action_t            op;
  logic [ID_BITS-1:0] new_id;
  logic               new_prem;
  logic [ID_BITS-1:0] head_id;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   q_idx;
  logic               dv;
  logic               seen_np;
  logic               ins_done;
  logic [CNT_W-1:0]   pos;
  logic               unaged_seen;
  logic [CNT_W-1:0]   n_moved;
  logic [CNT_W-1:0]   n_mv_wr;
  logic [CNT_W-1:0]   n_kept;

  logic [ID_BITS-1:0]  q_id;
  logic                q_prem;
  logic [AGE_BITS-1:0] q_age;
  logic [AGE_BITS-1:0] age_inc;
  logic                full;
  logic                empty;
  logic                issue;
  logic                aged;
  logic                moved;
  logic                ins_here;
  logic                flip;
  logic [CNT_W-1:0]    count_next;
  status_t             status_next;

  logic               we;
  logic [IDX_W:0]     waddr;
  logic [ENTRY_W-1:0] wdata;

  assign q_id   = q[ENTRY_W-1 -: ID_BITS];
  assign q_prem = q[AGE_BITS];
  assign q_age  = q[AGE_BITS-1:0];

  assign full  = (CAP_CMP_W'(count) >= CAP_CMP_W'(capacity)) ||
                 (count >= CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign issue = (cmd.scan || cmd.sweep) && (rd_idx < count);

  assign age_inc  = (q_age == AGE_MAX) ? q_age : q_age + AGE_ONE;
  assign aged     = AGE_CMP_W'(q_age) >= AGE_CMP_W'(max_wait);
  assign moved    = aged && unaged_seen;
  assign ins_here = !ins_done && ((!q_prem && new_prem) || (q_prem && seen_np));

  assign sts.full       = full;
  assign sts.empty      = empty;
  assign sts.sweep_done = (rd_idx == count) && !dv;
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    count_next  = count;
    flip        = 1'b0;
    status_next = ST_DONE;
    case (op)
      ACT_PRIO_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
          flip       = 1'b1;
        end
      end
      ACT_FIFO_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          flip       = 1'b1;
        end
      end
      default: flip = !empty;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.sweep && dv) begin
      case (op)
        ACT_PRIO_ENQ: begin
          we    = 1'b1;
          waddr = {~bank, IDX_W'(q_idx + CNT_W'(ins_done || ins_here))};
          wdata = {q_id, q_prem, age_inc};
        end
        ACT_DEQ: begin
          if (q_idx != '0) begin
            we    = 1'b1;
            waddr = {~bank, IDX_W'(q_idx - 1'b1)};
            wdata = q;
          end
        end
        ACT_PROMOTE: begin
          we    = 1'b1;
          waddr = {~bank, IDX_W'(moved ? n_moved - n_mv_wr - 1'b1 : n_moved + n_kept)};
          wdata = {q_id, q_prem, (aged ? {AGE_BITS{1'b0}} : q_age)};
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.commit && !full) begin
      case (op)
        ACT_PRIO_ENQ: begin
          we    = 1'b1;
          waddr = {~bank, IDX_W'(pos)};
          wdata = {new_id, new_prem, AGE_ONE};
        end
        ACT_FIFO_ENQ: begin
          we    = 1'b1;
          waddr = {bank, IDX_W'(count)};
          wdata = {new_id, 1'b0, {AGE_BITS{1'b0}}};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[{bank, IDX_W'(rd_idx)}];
    if (cmd.load) begin
      new_id   <= ID_BITS'(client_id);
      new_prem <= premium;
    end
    if (cmd.sweep && dv && (op == ACT_DEQ) && (q_idx == '0)) begin
      head_id <= q_id;
    end
    if (cmd.commit) begin
      out_status    <= status_next;
      out_client_id <= ((op == ACT_DEQ) && !empty) ? CLIENT_ID_W'(head_id) : '0;
      out_occupancy <= OCC_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank        <= 1'b0;
      count       <= '0;
      op          <= ACT_PRIO_ENQ;
      rd_idx      <= '0;
      q_idx       <= '0;
      dv          <= 1'b0;
      seen_np     <= 1'b0;
      ins_done    <= 1'b0;
      pos         <= '0;
      unaged_seen <= 1'b0;
      n_moved     <= '0;
      n_mv_wr     <= '0;
      n_kept      <= '0;
      out_valid   <= 1'b0;
    end else begin
      dv    <= issue;
      q_idx <= rd_idx;
      if (cmd.load) begin
        op          <= action;
        rd_idx      <= '0;
        seen_np     <= 1'b0;
        ins_done    <= 1'b0;
        pos         <= count;
        unaged_seen <= 1'b0;
        n_moved     <= '0;
        n_mv_wr     <= '0;
        n_kept      <= '0;
      end else if (cmd.restart) begin
        rd_idx      <= '0;
        unaged_seen <= 1'b0;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (cmd.scan && dv) begin
          if (!aged) begin
            unaged_seen <= 1'b1;
          end else if (unaged_seen) begin
            n_moved <= n_moved + 1'b1;
          end
        end
        if (cmd.sweep && dv) begin
          case (op)
            ACT_PRIO_ENQ: begin
              if (!q_prem) begin
                seen_np <= 1'b1;
              end
              if (ins_here) begin
                ins_done <= 1'b1;
                pos      <= q_idx;
              end
            end
            ACT_PROMOTE: begin
              if (!aged) begin
                unaged_seen <= 1'b1;
              end
              if (moved) begin
                n_mv_wr <= n_mv_wr + 1'b1;
              end else begin
                n_kept <= n_kept + 1'b1;
              end
            end
            default: seen_np <= seen_np;
          endcase
        end
      end
      if (cmd.commit) begin
        count     <= count_next;
        bank      <= bank ^ flip;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/two_class_aging_priority_queue_core.sv =====
// Channel   Role        Payload
// req       sink        action, client_id, premium
// rsp       source      status, out_client_id, occupancy
// apb       slave       capacity at 0x0, max_wait at 0x4
//
// A FIFO enqueue or a rejected or empty operation goes from acceptance straight to its commit;
// a priority enqueue or dequeue first sweeps the store, and a promote scans it and then sweeps it:
// the store is read one entry per cycle, twice for a promote.
// A new transaction is accepted only after the previous result is registered.
// Reset is synchronous and empties the queue; stored entries are not cleared.
// A held result stalls the commit of the following transaction and so its successor.
module two_class_aging_priority_queue_core #(
  parameter int QUEUE_DEPTH = tcapq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = tcapq_pkg::DEF_ID_BITS,
  parameter int AGE_BITS    = tcapq_pkg::DEF_AGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  tcapq_req_if.sink                     req,
  tcapq_rsp_if.source                   rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcapq_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcapq_pkg::DATA_W-1:0]  pwdata,
  output logic [tcapq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import tcapq_pkg::*;

  logic [CAP_W-1:0]      capacity;
  logic [MAX_WAIT_W-1:0] max_wait;
  reg_idx_t              reg_sel;
  action_t               action;
  dp_cmd_t               cmd;
  dp_sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign action  = action_t'(req.action);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      max_wait <= MAX_WAIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_CAPACITY: capacity <= pwdata[CAP_W-1:0];
        REG_MAX_WAIT: max_wait <= pwdata[MAX_WAIT_W-1:0];
        default:      capacity <= capacity;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPACITY: prdata = DATA_W'(capacity);
      REG_MAX_WAIT: prdata = DATA_W'(max_wait);
      default:      prdata = '0;
    endcase
  end

  tcapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .action    (action),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcapq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .client_id     (req.client_id),
    .premium       (req.premium),
    .capacity      (capacity),
    .max_wait      (max_wait),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_status    (rsp.status),
    .out_client_id (rsp.out_client_id),
    .out_occupancy (rsp.occupancy)
  );

endmodule

// ===== rtl/tcapq_checker.sv =====
module tcapq_checker #(
  parameter int QUEUE_DEPTH = tcapq_pkg::DEF_QUEUE_DEPTH
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [tcapq_pkg::STATUS_W-1:0]    rsp_status,
  input logic [tcapq_pkg::CLIENT_ID_W-1:0] rsp_client_id,
  input logic [tcapq_pkg::OCC_W-1:0]       rsp_occupancy
);
  import tcapq_pkg::*;

  localparam int OCC_LIMIT = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_client_id) && $stable(rsp_occupancy))
    else $error("Result transaction changed while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0) && (rsp_client_id == '0))
    else $error("Empty status reported with a nonempty queue or an id.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= OCC_W'(OCC_LIMIT))
    else $error("Occupancy exceeds the queue depth.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_DONE) || (rsp_status == ST_EMPTY) ||
      (rsp_status == ST_FULL))
    else $error("Undefined status code.");

endmodule

bind two_class_aging_priority_queue_core tcapq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tcapq_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_client_id (rsp.out_client_id),
  .rsp_occupancy (rsp.occupancy)
);

// ===== verif/two_class_aging_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps

module two_class_aging_priority_queue_core_tb;
  import tcapq_pkg::*;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int AGE_W       = DEF_AGE_BITS;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 50;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    status_t                status;
    logic [CLIENT_ID_W-1:0] client_id;
    logic [OCC_W-1:0]       occupancy;
  } queue_result_t;

  class client_queue_tracker;
    bit [CLIENT_ID_W-1:0] ids[DEPTH];
    bit                   premium_flags[DEPTH];
    bit [AGE_W-1:0]       ages[DEPTH];
    int                   count;
    bit [CAP_W-1:0]       capacity;
    bit [MAX_WAIT_W-1:0]  max_wait;
    queue_result_t        expected_results[$];
    int                   failures;

    function new();
      count = 0;
      capacity = CAP_RESET;
      max_wait = MAX_WAIT_RESET;
      failures = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void insert_client(int pos, bit [CLIENT_ID_W-1:0] id, bit is_premium);
      int i;
      for (i = count; i > pos; i--) begin
        ids[i] = ids[i-1];
        premium_flags[i] = premium_flags[i-1];
        ages[i] = ages[i-1];
      end
      ids[pos] = id;
      premium_flags[pos] = is_premium;
      ages[pos] = '0;
      count++;
    endfunction

    // Aged entries behind an unaged one jump to the front, last found first.
    function void promote_aged();
      bit [CLIENT_ID_W-1:0] moved_id[DEPTH];
      bit                   moved_prem[DEPTH];
      bit [CLIENT_ID_W-1:0] kept_id[DEPTH];
      bit                   kept_prem[DEPTH];
      bit [AGE_W-1:0]       kept_age[DEPTH];
      int                   n_moved;
      int                   n_kept;
      int                   i;
      int                   o;
      bit                   unaged_seen;
      n_moved = 0;
      n_kept = 0;
      unaged_seen = 1'b0;
      for (i = 0; i < count; i++) begin
        if (ages[i] >= max_wait) begin
          if (unaged_seen) begin
            moved_id[n_moved] = ids[i];
            moved_prem[n_moved] = premium_flags[i];
            n_moved++;
          end else begin
            kept_id[n_kept] = ids[i];
            kept_prem[n_kept] = premium_flags[i];
            kept_age[n_kept] = '0;
            n_kept++;
          end
        end else begin
          unaged_seen = 1'b1;
          kept_id[n_kept] = ids[i];
          kept_prem[n_kept] = premium_flags[i];
          kept_age[n_kept] = ages[i];
          n_kept++;
        end
      end
      o = 0;
      for (i = n_moved - 1; i >= 0; i--) begin
        ids[o] = moved_id[i];
        premium_flags[o] = moved_prem[i];
        ages[o] = '0;
        o++;
      end
      for (i = 0; i < n_kept; i++) begin
        ids[o] = kept_id[i];
        premium_flags[o] = kept_prem[i];
        ages[o] = kept_age[i];
        o++;
      end
    endfunction

    function void note_request(action_t act, bit [CLIENT_ID_W-1:0] id, bit is_premium);
      queue_result_t r;
      int            limit;
      int            pos;
      int            i;
      r.status = ST_DONE;
      r.client_id = '0;
      limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
      case (act) inside
        ACT_PRIO_ENQ, ACT_FIFO_ENQ: begin
          if (count >= limit) begin
            r.status = ST_FULL;
          end else if (act == ACT_FIFO_ENQ) begin
            insert_client(count, id, 1'b0);
          end else begin
            pos = 0;
            while (pos < count && premium_flags[pos]) pos++;
            if (!is_premium) begin
              while (pos < count && !premium_flags[pos]) pos++;
            end
            insert_client(pos, id, is_premium);
            for (i = 0; i < count; i++) begin
              if (ages[i] != '1) ages[i]++;
            end
          end
        end
        ACT_DEQ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.client_id = ids[0];
            for (i = 1; i < count; i++) begin
              ids[i-1] = ids[i];
              premium_flags[i-1] = premium_flags[i];
              ages[i-1] = ages[i];
            end
            count--;
          end
        end
        default: begin
          promote_aged();
        end
      endcase
      r.occupancy = OCC_W'(count);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [CLIENT_ID_W-1:0] id,
                               logic [OCC_W-1:0] occupancy);
      queue_result_t e;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected transaction: status %0d id %h occupancy %0d",
                   status, id, occupancy);
        end
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status || id !== e.client_id || occupancy !== e.occupancy) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: expected status %0d id %h occupancy %0d, got %0d %h %0d",
                   e.status, e.client_id, e.occupancy, status, id, occupancy);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  tcapq_req_if req_ch ();
  tcapq_rsp_if rsp_ch ();

  client_queue_tracker tracker;
  int                  req_idle_pct;
  int                  rsp_idle_pct;
  bit                  hold_pending;
  int                  cycle_count = 0;

  two_class_aging_priority_queue_core u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_class_aging_priority_queue_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_result(rsp_ch.status, rsp_ch.out_client_id, rsp_ch.occupancy);
      end
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_request(action_t'(req_ch.action), req_ch.client_id, req_ch.premium);
      end
    end
  end

  initial begin : rsp_side
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  task automatic send_request(action_t act, logic [CLIENT_ID_W-1:0] id, logic is_premium);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.client_id <= id;
    req_ch.premium <= is_premium;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic release_request();
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_until_drained(int settle);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << REG_SEL_BIT;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CAPACITY) begin
      tracker.capacity = value[CAP_W-1:0];
    end else begin
      tracker.max_wait = value[MAX_WAIT_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reconfigure(int cap, int wait_limit);
    release_request();
    wait_until_drained(SETTLE_CYCLES);
    write_register(REG_CAPACITY, DATA_W'(cap));
    write_register(REG_MAX_WAIT, DATA_W'(wait_limit));
  endtask

  task automatic random_requests(int n);
    int      k;
    int      pick;
    bit      filling;
    action_t act;
    filling = 1'b1;
    for (k = 0; k < n; k++) begin
      if (k % 20 == 0) filling = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (filling) begin
        act = (pick < 45) ? ACT_PRIO_ENQ : (pick < 70) ? ACT_FIFO_ENQ :
              (pick < 85) ? ACT_DEQ : ACT_PROMOTE;
      end else begin
        act = (pick < 20) ? ACT_PRIO_ENQ : (pick < 30) ? ACT_FIFO_ENQ :
              (pick < 85) ? ACT_DEQ : ACT_PROMOTE;
      end
      send_request(act, CLIENT_ID_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_setting(int cap, int wait_limit, int n);
    reconfigure(cap, wait_limit);
    random_requests(n);
  endtask

  initial begin : stimulus
    int k;
    tracker = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PRIO_ENQ;
    req_ch.client_id = '0;
    req_ch.premium = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_idle_pct = 38;
    rsp_idle_pct = 84;
    hold_pending = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(ACT_DEQ, 16'hFFFF, 1'b1);
    send_request(ACT_PROMOTE, 16'h0000, 1'b0);
    send_request(ACT_PRIO_ENQ, 16'hFFFF, 1'b1);
    send_request(ACT_PRIO_ENQ, 16'h0000, 1'b0);
    send_request(ACT_FIFO_ENQ, 16'hA5A5, 1'b1);
    send_request(ACT_PRIO_ENQ, 16'h5A5A, 1'b1);
    send_request(ACT_PRIO_ENQ, 16'h1234, 1'b0);
    for (k = 0; k < 7; k++) begin
      send_request(ACT_PRIO_ENQ, CLIENT_ID_W'(16'h0100 + k), 1'b0);
    end
    send_request(ACT_PROMOTE, '0, 1'b0);
    send_request(ACT_DEQ, '0, 1'b0);
    send_request(ACT_DEQ, '0, 1'b0);
    reconfigure(2, 0);
    send_request(ACT_PRIO_ENQ, 16'hC3C3, 1'b1);
    send_request(ACT_FIFO_ENQ, 16'h3C3C, 1'b0);
    send_request(ACT_PROMOTE, '0, 1'b0);
    send_request(ACT_DEQ, '0, 1'b0);
    reconfigure(0, 1);
    send_request(ACT_FIFO_ENQ, 16'h8001, 1'b0);
    send_request(ACT_DEQ, '0, 1'b0);

    run_setting(16, 8, 110);
    run_setting(1, 65535, 100);
    run_setting(31, 1, 110);

    req_idle_pct = 84;
    rsp_idle_pct = 38;
    run_setting(0, 0, 40);
    run_setting(5, 3, 110);
    run_setting(12, 2, 110);

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    reconfigure(16, 4);
    hold_pending = 1'b1;
    random_requests(130);
    run_setting(7, 6, 140);

    release_request();
    wait_until_drained(DRAIN_CYCLES);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("two_class_aging_priority_queue_core verification clean");
    end else begin
      $display("two_class_aging_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule
